[rtl/core/v2e_pkg.sv]
// Shared constants, register codes and pipeline stage types for the equirect pixel unit.
`default_nettype none

package v2e_pkg;

   localparam int DefAngleIterations = 24;
   localparam int AtanTabLen         = 40;
   localparam int IsqrtSteps         = 32;
   localparam int PrescaleShift      = 24;
   localparam int CsrAddrWidth       = 4;

   localparam logic [31:0] TwoPiQ29 = 32'd3373259426;

   // atan(2^-i) in binary angle units, full turn = 2^32
   localparam logic [31:0] AtanTab [AtanTabLen] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
   };

   typedef enum logic [1:0] {
      CsrScaleX  = 2'd0,
      CsrScaleY  = 2'd1,
      CsrCenterX = 2'd2,
      CsrCenterY = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic nonzero;
      logic lon_zero;
      logic z_neg;
      logic x_neg;
   } flags_type;

   typedef struct packed {
      flags_type          flags;
      logic [63:0]        v;
      logic [63:0]        root;
      logic signed [32:0] cx;
      logic signed [32:0] cy;
      logic signed [31:0] y;
   } isq_type;

   typedef struct packed {
      flags_type          flags;
      logic signed [63:0] lx;
      logic signed [63:0] ly;
      logic signed [33:0] la;
      logic signed [63:0] tx;
      logic signed [63:0] ty;
      logic signed [33:0] ta;
   } cor_type;

endpackage

`default_nettype wire

[rtl/core/v2e_dir_if.sv]
// Direction input channel: valid/ready handshake with the three vector components.
`default_nettype none

interface v2e_dir_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;

   modport source (output valid, dir_x, dir_y, dir_z, input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

`default_nettype wire

[rtl/core/v2e_pix_if.sv]
// Pixel result channel: valid/ready handshake with the projected coordinates.
`default_nettype none

interface v2e_pix_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_u;
   logic signed [31:0] pixel_v;
   logic               valid_res;

   modport source (output valid, pixel_u, pixel_v, valid_res, input ready);
   modport sink   (input valid, pixel_u, pixel_v, valid_res, output ready);
endinterface

`default_nettype wire

[rtl/core/vector_to_equirect_pixel_unit.sv]
// Direction to equirectangular pixel: isqrt, twin vectoring CORDIC and affine scaling pipeline.
// Usage:
//   req carries one direction (dir_x, dir_y, dir_z) per beat; rsp returns one beat per
//   request with pixel_u, pixel_v (signed Q20.12) and valid_res (0 for the zero vector).
//   The csr APB port holds scale_x, scale_y (Q16.16) at 0x0/0x4 and center_x, center_y
//   (Q20.12) at 0x8/0xC; write them only while no beat is in flight.
// Timing:
//   The pipeline is the input, square and sum stages, the 32 stages of the bit-pair square
//   root, one stage per CORDIC iteration (capped at 40), then angle fold, three scaling
//   stages and the output register.
//   Throughput is one beat per cycle while rsp is not stalled.
// Reset:
//   Synchronous reset empties the pipeline and loads unit scale and zero center.
// Backpressure:
//   The whole pipeline advances together whenever the output register is empty or being
//   taken; while rsp stalls with a beat held, req.ready drops and every stage holds.
`default_nettype none

module vector_to_equirect_pixel_unit
   import v2e_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = DefAngleIterations
) (
   input  wire                     clock,
   input  wire                     reset,
   v2e_dir_if.sink                 req,
   v2e_pix_if.source               rsp,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire [CsrAddrWidth-1:0]  csr_paddr,
   input  wire [31:0]              csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int CorStages = (ANGLE_ITERATIONS > AtanTabLen) ? AtanTabLen : ANGLE_ITERATIONS;

   logic adv;

   logic [31:0] scale_x_ff, scale_y_ff, center_x_ff, center_y_ff;
   csr_index_type csr_idx;

   // input stage
   logic               in_vld_ff;
   logic signed [31:0] in_x_ff, in_y_ff, in_z_ff;

   // squares stage (v holds x^2, root holds z^2)
   logic    sq_vld_ff;
   isq_type sq_in, sq_ff;
   logic [31:0] ax, az;
   isq_type sum_in;

   logic    isq_vld_ff [0:IsqrtSteps];
   isq_type isq_ff     [0:IsqrtSteps];

   logic    cor_vld_ff [0:CorStages-1];
   cor_type cor_ff     [0:CorStages-1];
   cor_type cor_src    [0:CorStages-1];

   // angle fold stage
   logic               post_vld_ff, post_nz_ff;
   logic               lon_neg_ff, lat_neg_ff;
   logic [31:0]        lon_mag_ff, lat_mag_ff;
   logic signed [34:0] lon_base, lon_sum, lon_clip;
   logic signed [33:0] lat_ang;

   logic        p1_vld_ff, p1_nz_ff, p1_un_ff, p1_vn_ff;
   logic [63:0] p1_u_ff, p1_v_ff;
   logic        p2_vld_ff, p2_nz_ff, p2_un_ff, p2_vn_ff;
   logic [31:0] p2_u_ff, p2_v_ff;
   logic        p3_vld_ff, p3_nz_ff, p3_un_ff, p3_vn_ff;
   logic [63:0] p3_u_ff, p3_v_ff;

   logic [63:0]        off_u_wide, off_v_wide;
   logic signed [33:0] sum_u, sum_v;
   logic signed [31:0] pix_u, pix_v;

   logic               rsp_vld_ff, rsp_res_ff;
   logic signed [31:0] rsp_u_ff, rsp_v_ff;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= 32'd65536;
         scale_y_ff  <= 32'd65536;
         center_x_ff <= 32'd0;
         center_y_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            CsrScaleX:  scale_x_ff  <= csr_pwdata;
            CsrScaleY:  scale_y_ff  <= csr_pwdata;
            CsrCenterX: center_x_ff <= csr_pwdata;
            CsrCenterY: center_y_ff <= csr_pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CsrScaleX:  csr_prdata = scale_x_ff;
         CsrScaleY:  csr_prdata = scale_y_ff;
         CsrCenterX: csr_prdata = center_x_ff;
         CsrCenterY: csr_prdata = center_y_ff;
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- flow control ----------------
   assign adv       = !rsp_vld_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- input stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_x_ff <= req.dir_x;
         in_y_ff <= req.dir_y;
         in_z_ff <= req.dir_z;
      end
   end

   // ---------------- squares and lon operands ----------------
   always_comb begin
      ax = in_x_ff[31] ? 32'(-in_x_ff) : 32'(in_x_ff);
      az = in_z_ff[31] ? 32'(-in_z_ff) : 32'(in_z_ff);
      sq_in.flags.nonzero  = (in_x_ff != 32'sd0) || (in_y_ff != 32'sd0) || (in_z_ff != 32'sd0);
      sq_in.flags.lon_zero = (in_x_ff == 32'sd0) && (in_z_ff == 32'sd0);
      sq_in.flags.z_neg    = in_z_ff[31];
      sq_in.flags.x_neg    = in_x_ff[31];
      sq_in.v    = 64'(ax) * 64'(ax);
      sq_in.root = 64'(az) * 64'(az);
      // for negative z, rotate by pi before the CORDIC
      sq_in.cx   = in_z_ff[31] ? -33'(in_z_ff) : 33'(in_z_ff);
      sq_in.cy   = in_z_ff[31] ? -33'(in_x_ff) : 33'(in_x_ff);
      sq_in.y    = in_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // ---------------- sum of squares ----------------
   always_comb begin
      sum_in      = sq_ff;
      sum_in.v    = sq_ff.v + sq_ff.root;
      sum_in.root = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         isq_vld_ff[0] <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         isq_ff[0] <= sum_in;
      end
   end

   // ---------------- square root, one bit pair per stage ----------------
   for (genvar k = 0; k < IsqrtSteps; k++) begin : g_isq
      localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
      isq_type     nxt;
      logic [63:0] trial;

      always_comb begin
         nxt   = isq_ff[k];
         trial = isq_ff[k].root + Bit;
         if (isq_ff[k].v >= trial) begin
            nxt.v    = isq_ff[k].v - trial;
            nxt.root = (isq_ff[k].root >> 1) + Bit;
         end else begin
            nxt.root = isq_ff[k].root >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            isq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            isq_vld_ff[k+1] <= isq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            isq_ff[k+1] <= nxt;
         end
      end
   end

   // ---------------- twin vectoring CORDIC ----------------
   always_comb begin
      cor_src[0].flags = isq_ff[IsqrtSteps].flags;
      cor_src[0].lx    = 64'(isq_ff[IsqrtSteps].cx) <<< PrescaleShift;
      cor_src[0].ly    = 64'(isq_ff[IsqrtSteps].cy) <<< PrescaleShift;
      cor_src[0].la    = 34'sd0;
      cor_src[0].tx    = $signed(isq_ff[IsqrtSteps].root << PrescaleShift);
      cor_src[0].ty    = 64'(isq_ff[IsqrtSteps].y) <<< PrescaleShift;
      cor_src[0].ta    = 34'sd0;
   end

   for (genvar i = 0; i < CorStages; i++) begin : g_cor
      localparam logic signed [33:0] Step = $signed(34'(AtanTab[i]));
      cor_type nxt;

      if (i > 0) begin : g_link
         assign cor_src[i] = cor_ff[i-1];
      end

      always_comb begin
         nxt = cor_src[i];
         if (cor_src[i].ly < 0) begin
            nxt.lx = cor_src[i].lx - (cor_src[i].ly >>> i);
            nxt.ly = cor_src[i].ly + (cor_src[i].lx >>> i);
            nxt.la = cor_src[i].la - Step;
         end else begin
            nxt.lx = cor_src[i].lx + (cor_src[i].ly >>> i);
            nxt.ly = cor_src[i].ly - (cor_src[i].lx >>> i);
            nxt.la = cor_src[i].la + Step;
         end
         if (cor_src[i].ty < 0) begin
            nxt.tx = cor_src[i].tx - (cor_src[i].ty >>> i);
            nxt.ty = cor_src[i].ty + (cor_src[i].tx >>> i);
            nxt.ta = cor_src[i].ta - Step;
         end else begin
            nxt.tx = cor_src[i].tx + (cor_src[i].ty >>> i);
            nxt.ty = cor_src[i].ty - (cor_src[i].tx >>> i);
            nxt.ta = cor_src[i].ta + Step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cor_vld_ff[i] <= 1'b0;
         end else if (adv) begin
            cor_vld_ff[i] <= (i == 0) ? isq_vld_ff[IsqrtSteps] : cor_vld_ff[(i == 0) ? 0 : i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cor_ff[i] <= nxt;
         end
      end
   end

   // ---------------- fold angles to sign and magnitude ----------------
   always_comb begin
      if (!cor_ff[CorStages-1].flags.z_neg) begin
         lon_base = 35'sd0;
      end else if (cor_ff[CorStages-1].flags.x_neg) begin
         lon_base = -35'sd2147483648;
      end else begin
         lon_base = 35'sd2147483648;
      end
      lon_sum = lon_base + 35'(cor_ff[CorStages-1].la);
      priority if (cor_ff[CorStages-1].flags.lon_zero) begin
         lon_clip = 35'sd0;
      end else if (lon_sum > 35'sd2147483648) begin
         lon_clip = 35'sd2147483648;
      end else if (lon_sum < -35'sd2147483648) begin
         lon_clip = -35'sd2147483648;
      end else begin
         lon_clip = lon_sum;
      end
      lat_ang = cor_ff[CorStages-1].ta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (adv) begin
         post_vld_ff <= cor_vld_ff[CorStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         post_nz_ff <= cor_ff[CorStages-1].flags.nonzero;
         lon_neg_ff <= lon_clip[34];
         lat_neg_ff <= lat_ang[33];
         lon_mag_ff <= lon_clip[34] ? 32'(-lon_clip) : 32'(lon_clip);
         lat_mag_ff <= lat_ang[33] ? 32'(-lat_ang) : 32'(lat_ang);
      end
   end

   // ---------------- binary angle to radians, then scale ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= post_vld_ff;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_nz_ff <= post_nz_ff;
         p1_un_ff <= lon_neg_ff;
         p1_vn_ff <= lat_neg_ff;
         p1_u_ff  <= 64'(lon_mag_ff) * 64'(TwoPiQ29);
         p1_v_ff  <= 64'(lat_mag_ff) * 64'(TwoPiQ29);

         p2_nz_ff <= p1_nz_ff;
         p2_un_ff <= p1_un_ff;
         p2_vn_ff <= p1_vn_ff;
         p2_u_ff  <= 32'((p1_u_ff + 64'h8000_0000) >> 32);
         p2_v_ff  <= 32'((p1_v_ff + 64'h8000_0000) >> 32);

         p3_nz_ff <= p2_nz_ff;
         p3_un_ff <= p2_un_ff;
         p3_vn_ff <= p2_vn_ff;
         p3_u_ff  <= 64'(scale_x_ff) * 64'(p2_u_ff);
         p3_v_ff  <= 64'(scale_y_ff) * 64'(p2_v_ff);
      end
   end

   // ---------------- offset, center and saturate ----------------
   always_comb begin
      off_u_wide = (p3_u_ff + 64'h1_0000_0000) >> 33;
      off_v_wide = (p3_v_ff + 64'h1_0000_0000) >> 33;
      sum_u = p3_un_ff ? 34'($signed(center_x_ff)) - $signed({2'b00, off_u_wide[31:0]})
                       : 34'($signed(center_x_ff)) + $signed({2'b00, off_u_wide[31:0]});
      sum_v = p3_vn_ff ? 34'($signed(center_y_ff)) - $signed({2'b00, off_v_wide[31:0]})
                       : 34'($signed(center_y_ff)) + $signed({2'b00, off_v_wide[31:0]});
      priority if (sum_u > 34'sd2147483647) begin
         pix_u = 32'sh7FFF_FFFF;
      end else if (sum_u < -34'sd2147483648) begin
         pix_u = 32'sh8000_0000;
      end else begin
         pix_u = sum_u[31:0];
      end
      priority if (sum_v > 34'sd2147483647) begin
         pix_v = 32'sh7FFF_FFFF;
      end else if (sum_v < -34'sd2147483648) begin
         pix_v = 32'sh8000_0000;
      end else begin
         pix_v = sum_v[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= p3_vld_ff;
      end
   end

   // zero vector drops to all-zero outputs
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_ff <= p3_nz_ff;
         rsp_u_ff   <= p3_nz_ff ? pix_u : 32'sd0;
         rsp_v_ff   <= p3_nz_ff ? pix_v : 32'sd0;
      end
   end

   assign rsp.valid     = rsp_vld_ff;
   assign rsp.pixel_u   = rsp_u_ff;
   assign rsp.pixel_v   = rsp_v_ff;
   assign rsp.valid_res = rsp_res_ff;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the direction to equirectangular pixel unit.
`default_nettype none

module tb;
   import v2e_pkg::*;

   localparam int Iterations = DefAngleIterations;
   localparam int Latency    = Iterations + 40;
   localparam int StallLimit = 4000;
   localparam longint HalfTurn = 64'sd2147483648;

   typedef struct {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic               valid_res;
   } pixel_type;

   class pixel_scoreboard;
      logic [31:0] scale_x, scale_y;
      logic signed [31:0] center_x, center_y;
      pixel_type pending_pixels[$];
      int errors;

      function new();
         scale_x = 32'd65536;
         scale_y = 32'd65536;
         center_x = 0;
         center_y = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CsrScaleX:  scale_x = value;
            CsrScaleY:  scale_y = value;
            CsrCenterX: center_x = value;
            CsrCenterY: center_y = value;
         endcase
      endfunction

      function longint vector_angle(longint vx, longint vy);
         longint ang, dx, dy;
         ang = 0;
         vx = vx * 64'sd16777216;
         vy = vy * 64'sd16777216;
         for (int i = 0; i < Iterations && i < AtanTabLen; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy < 0) begin
               vx -= dx;
               vy += dy;
               ang -= longint'({32'b0, AtanTab[i]});
            end else begin
               vx += dx;
               vy -= dy;
               ang += longint'({32'b0, AtanTab[i]});
            end
         end
         return ang;
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function logic signed [31:0] angle_to_pixel(longint ang, logic [31:0] scale,
                                                  logic signed [31:0] center);
         longint unsigned mag, rad, off;
         longint sum;
         mag = (ang < 0) ? longint'(-ang) : longint'(ang);
         rad = (mag * 64'd3373259426 + (64'd1 << 31)) >> 32;
         off = ({32'b0, scale} * rad + (64'd1 << 32)) >> 33;
         sum = longint'(center) + ((ang < 0) ? -longint'(off) : longint'(off));
         if (sum > 64'sd2147483647) sum = 64'sd2147483647;
         if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         return sum[31:0];
      endfunction

      function void note_dir(logic signed [31:0] dx, logic signed [31:0] dy,
                             logic signed [31:0] dz);
         pixel_type p;
         longint x, y, z, lon, lat;
         longint unsigned ax, az;
         x = dx; y = dy; z = dz;
         if (x == 0 && y == 0 && z == 0) begin
            p.pixel_u = 0; p.pixel_v = 0; p.valid_res = 0;
         end else begin
            if (x == 0 && z == 0) begin
               lon = 0;
            end else if (z < 0) begin
               // fold into the right half plane, then clamp to a half turn
               lon = ((x >= 0) ? HalfTurn : -HalfTurn) + vector_angle(-z, -x);
               if (lon > HalfTurn) lon = HalfTurn;
               if (lon < -HalfTurn) lon = -HalfTurn;
            end else begin
               lon = vector_angle(z, x);
            end
            ax = (x < 0) ? -x : x;
            az = (z < 0) ? -z : z;
            lat = vector_angle(longint'(floor_root(ax * ax + az * az)), y);
            p.pixel_u = angle_to_pixel(lon, scale_x, center_x);
            p.pixel_v = angle_to_pixel(lat, scale_y, center_y);
            p.valid_res = 1;
         end
         pending_pixels.push_back(p);
      endfunction

      function void check_pixel(logic signed [31:0] u, logic signed [31:0] v, logic vr);
         pixel_type e;
         if (pending_pixels.size() == 0) begin
            $error("unexpected beat u=%0d v=%0d valid_res=%0d", u, v, vr);
            errors++;
            return;
         end
         e = pending_pixels.pop_front();
         if (u !== e.pixel_u) begin
            $error("pixel_u expected %0d actual %0d", e.pixel_u, u);
            errors++;
         end
         if (v !== e.pixel_v) begin
            $error("pixel_v expected %0d actual %0d", e.pixel_v, v);
            errors++;
         end
         if (vr !== e.valid_res) begin
            $error("valid_res expected %0d actual %0d", e.valid_res, vr);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   v2e_dir_if req_if ();
   v2e_pix_if rsp_if ();

   vector_to_equirect_pixel_unit dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pixel_scoreboard sb = new();
   bit calm;
   int pixels_seen;
   int quiet_cycles;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_dir(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
      if (!calm && $urandom_range(99) < 16) begin
         req_if.valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < 30) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.dir_x <= x;
      req_if.dir_y <= y;
      req_if.dir_z <= z;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_dir(x, y, z);
   endtask

   task automatic drain();
      req_if.valid <= 0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(2000) - 1000;
         2: return 0;
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   task automatic random_run(int count);
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3) && (n < count / 3 + 80);
         send_dir(rand_comp(), rand_comp(), rand_comp());
      end
      calm = 0;
   endtask

   // Result side: random stalls plus one long hold-off to back the pipeline up
   initial begin
      bit held;
      rsp_if.ready = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_pixel(rsp_if.pixel_u, rsp_if.pixel_v, rsp_if.valid_res);
            pixels_seen++;
         end
         if (!held && pixels_seen == 300) begin
            held = 1;
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
            rsp_if.ready <= 1;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFFFFFF;
      mn = 32'sh80000000;
      reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      req_if.valid = 0; req_if.dir_x = 0; req_if.dir_y = 0; req_if.dir_z = 0;
      calm = 0; pixels_seen = 0; quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero vector, poles, rear hemisphere on both sides, field extremes
      send_dir(0, 0, 0);
      send_dir(0, 1, 0);
      send_dir(0, -1, 0);
      send_dir(0, mx, 0);
      send_dir(0, mn, 0);
      send_dir(0, 0, 1);
      send_dir(0, 0, -1);
      send_dir(1, 0, 0);
      send_dir(-1, 0, 0);
      send_dir(0, 5, -7);
      send_dir(3, 2, -9);
      send_dir(-3, 2, -9);
      send_dir(mx, mx, mx);
      send_dir(mn, mn, mn);
      send_dir(mx, mn, mn);
      send_dir(mn, mx, mn);
      send_dir(mn, 0, mx);
      send_dir(mx, 0, mn);
      send_dir(-1, -1, mn);
      send_dir(1000, -200, 1000);
      drain();

      write_csr(CsrScaleX, 32'hFFFFFFFF);
      write_csr(CsrScaleY, 32'hFFFFFFFF);
      write_csr(CsrCenterX, mx);
      write_csr(CsrCenterY, mn);
      send_dir(mx, mx, mx);
      send_dir(mn, mn, mn);
      send_dir(-1, 1, -1);
      send_dir(1, -1, -1);
      random_run(150);
      drain();

      write_csr(CsrScaleX, 0);
      write_csr(CsrScaleY, 0);
      write_csr(CsrCenterX, mn);
      write_csr(CsrCenterY, mx);
      random_run(100);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CsrScaleX, $urandom);
         write_csr(CsrScaleY, $urandom_range(32'h00400000));
         write_csr(CsrCenterX, $urandom);
         write_csr(CsrCenterY, $urandom_range(32'h01000000));
         random_run(200);
         drain();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

`default_nettype wire

[files.f]
rtl/core/v2e_pkg.sv
rtl/core/v2e_dir_if.sv
rtl/core/v2e_pix_if.sv
rtl/core/vector_to_equirect_pixel_unit.sv
tb/tb.sv
